/* design/grp_pkg.sv */
// ============================================================================
// grp_pkg: shared types and constants of the guillotine rectangle packer
// Holds the payload structs, the free-rectangle type and the controller links.
// ============================================================================
package grp_pkg;

    localparam int FREE_SLOTS = 64;
    localparam int MAX_SIDE   = 8192;
    localparam int SIDE_W     = 14;
    localparam int IDX_W      = $clog2(FREE_SLOTS);
    localparam int CNT_W      = $clog2(FREE_SLOTS + 1);

    localparam logic [1:0] ST_PLACED = 2'd0;
    localparam logic [1:0] ST_NOFIT  = 2'd1;
    localparam logic [1:0] ST_NOSLOT = 2'd2;
    localparam logic [1:0] ST_START  = 2'd3;

    localparam logic OP_START = 1'b0;
    localparam logic OP_PLACE = 1'b1;

    localparam logic CFG_ATLAS_WIDTH  = 1'b0;
    localparam logic CFG_ATLAS_HEIGHT = 1'b1;

    typedef struct packed {
        logic              op;
        logic [SIDE_W-1:0] sprite_width;
        logic [SIDE_W-1:0] sprite_height;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [SIDE_W-1:0] x_min;
        logic [SIDE_W-1:0] y_min;
    } out_item_t;

    typedef struct packed {
        logic [SIDE_W-1:0] x;
        logic [SIDE_W-1:0] y;
        logic [SIDE_W-1:0] w;
        logic [SIDE_W-1:0] h;
    } rect_t;

    // Datapath operations issued by the controller.
    localparam logic [3:0] DP_NOP      = 4'd0;
    localparam logic [3:0] DP_START    = 4'd1;
    localparam logic [3:0] DP_SCAN_RD  = 4'd2;  // read the entry at addr
    localparam logic [3:0] DP_SCAN_CMP = 4'd3;  // compare read data with best
    localparam logic [3:0] DP_BEST_RD  = 4'd4;  // read best entry
    localparam logic [3:0] DP_SPLIT    = 4'd5;  // split best, check slots
    localparam logic [3:0] DP_SHIFT_RD = 4'd6;  // read entry m+1
    localparam logic [3:0] DP_SHIFT_WR = 4'd7;  // write it to m
    localparam logic [3:0] DP_APPEND   = 4'd8;  // append next part
    localparam logic [3:0] DP_MRG_RDA  = 4'd9;  // read entry i
    localparam logic [3:0] DP_MRG_RDB  = 4'd10; // latch a, read entry j
    localparam logic [3:0] DP_MRG_CMP  = 4'd11; // compare a with b
    localparam logic [3:0] DP_MRG_WR   = 4'd12; // write merged b

    typedef struct packed {
        logic [3:0]        op;
        logic [CNT_W-1:0]  addr;
    } dp_cmd_t;

    typedef struct packed {
        logic              fits;      // best rect holds the sprite
        logic              overflow;  // split would overflow
        logic [1:0]        parts;     // number of parts left to append
        logic              merge_hit; // a and b are mergeable
        logic [CNT_W-1:0]  count;
        logic [IDX_W-1:0]  best;
    } dp_stat_t;

endpackage

/* design/grp_datapath.sv */
// ============================================================================
// grp_datapath: free-rectangle memory, comparator, splitter and merge check
// Executes one command per cycle on the free list held in the mem array.
// ============================================================================
module grp_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  grp_pkg::dp_cmd_t       cmd,
    input  grp_pkg::in_item_t      item,
    input  logic [grp_pkg::SIDE_W-1:0] atlas_width,
    input  logic [grp_pkg::SIDE_W-1:0] atlas_height,
    output grp_pkg::dp_stat_t      stat,
    output logic [grp_pkg::SIDE_W-1:0] place_x,
    output logic [grp_pkg::SIDE_W-1:0] place_y
);
    import grp_pkg::*;

    rect_t mem [FREE_SLOTS];
    rect_t rd_reg;
    rect_t best_rect_reg, a_reg, pa_reg, pb_reg, merged_reg;
    logic [IDX_W-1:0] best_reg, best_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [1:0] parts_reg, parts_next;
    logic fits_reg, fits_next, ovf_reg, ovf_next, hit_reg, hit_next;
    logic [SIDE_W-1:0] px_reg, py_reg;
    logic              pa_ok, pb_ok;
    rect_t             pa_c, pb_c, merged_c;
    logic              we;
    logic [IDX_W-1:0]  waddr;
    rect_t             wdata;
    logic [IDX_W-1:0]  addr_i;

    assign addr_i = cmd.addr[IDX_W-1:0];

    function automatic logic signed [SIDE_W+1:0] leftover(rect_t r,
        logic [SIDE_W-1:0] sw, logic [SIDE_W-1:0] sh);
        logic signed [SIDE_W+1:0] dw, dh;
        dw = $signed({2'b00, r.w}) - $signed({2'b00, sw});
        dh = $signed({2'b00, r.h}) - $signed({2'b00, sh});
        return (dw < dh) ? dw : dh;
    endfunction

    logic signed [SIDE_W+1:0] lc, lb, lo;
    logic prefer;
    always_comb
    begin
        lc = leftover(rd_reg, item.sprite_width, item.sprite_height);
        lb = leftover(best_rect_reg, item.sprite_width, item.sprite_height);
        lo = (lc < lb) ? lc : lb;
        prefer = (lo < 0) ? (lb < lc) : (lc < lb);
    end

    // Split of the chosen rectangle.
    logic [SIDE_W-1:0] xmax, ymin;
    always_comb
    begin
        xmax = best_rect_reg.x + item.sprite_width;
        ymin = best_rect_reg.y + best_rect_reg.h - item.sprite_height;
        if (best_rect_reg.w < best_rect_reg.h)
        begin
            pa_c = '{x: xmax, y: best_rect_reg.y,
                     w: best_rect_reg.w - item.sprite_width, h: best_rect_reg.h};
            pb_c = '{x: best_rect_reg.x, y: best_rect_reg.y, w: item.sprite_width,
                     h: best_rect_reg.h - item.sprite_height};
        end
        else
        begin
            pa_c = '{x: best_rect_reg.x, y: best_rect_reg.y, w: best_rect_reg.w,
                     h: best_rect_reg.h - item.sprite_height};
            pb_c = '{x: xmax, y: ymin,
                     w: best_rect_reg.w - item.sprite_width, h: item.sprite_height};
        end
        pa_ok = (pa_c.w != '0) && (pa_c.h != '0);
        pb_ok = (pb_c.w != '0) && (pb_c.h != '0);
    end

    // Merge test: a is entry i (a_reg), b is entry j (rd_reg).
    logic vert, horz;
    always_comb
    begin
        vert = (a_reg.x == rd_reg.x) && (a_reg.w == rd_reg.w)
            && (a_reg.y == rd_reg.y + rd_reg.h);
        horz = (a_reg.y == rd_reg.y) && (a_reg.h == rd_reg.h)
            && (a_reg.x == rd_reg.x + rd_reg.w);
        merged_c = rd_reg;
        if (vert)
            merged_c.h = rd_reg.h + a_reg.h;
        else
            merged_c.w = rd_reg.w + a_reg.w;
    end

    always_comb
    begin
        we = 1'b0;
        waddr = addr_i;
        wdata = rd_reg;
        best_next = best_reg;
        count_next = count_reg;
        parts_next = parts_reg;
        fits_next = fits_reg;
        ovf_next = ovf_reg;
        hit_next = hit_reg;
        unique case (cmd.op)
            DP_START:
            begin
                we = 1'b1;
                waddr = '0;
                wdata = '{x: '0, y: '0, w: atlas_width, h: atlas_height};
                count_next = CNT_W'(1);
            end
            DP_SCAN_CMP:
                if (prefer)
                    best_next = addr_i;
            DP_BEST_RD:
                best_next = best_reg;
            DP_SPLIT:
            begin
                fits_next = (best_rect_reg.w >= item.sprite_width)
                         && (best_rect_reg.h >= item.sprite_height);
                parts_next = 2'({1'b0, pa_ok}) + 2'({1'b0, pb_ok});
                ovf_next = ({1'b0, count_reg} - 1'b1 + (CNT_W+1)'(parts_next))
                           > (CNT_W+1)'(FREE_SLOTS);
            end
            DP_SHIFT_WR:
                we = 1'b1;
            DP_APPEND:
            begin
                we = 1'b1;
                waddr = count_reg[IDX_W-1:0];
                wdata = (parts_reg == 2'd2 || !pb_ok) ? pa_reg : pb_reg;
                if (parts_reg == 2'd2 && !pa_ok)
                    wdata = pb_reg;
                count_next = count_reg + 1'b1;
                parts_next = parts_reg - 1'b1;
            end
            DP_MRG_CMP:
                hit_next = vert || horz;
            DP_MRG_WR:
            begin
                we = 1'b1;
                wdata = merged_reg;
            end
            default:
            begin
            end
        endcase
        // Removal shrinks the list once shifting is done (controller issues
        // DP_NOP with addr all ones to decrement).
        if (cmd.op == DP_NOP && cmd.addr == '1)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rd_reg <= mem[addr_i];
        if (cmd.op == DP_MRG_RDB)
            a_reg <= rd_reg;
        if (cmd.op == DP_MRG_CMP)
            merged_reg <= merged_c;
        if (cmd.op == DP_SCAN_CMP && prefer)
            best_rect_reg <= rd_reg;
        if (cmd.op == DP_SCAN_RD && cmd.addr == '0)
            best_rect_reg <= mem[0];
        if (cmd.op == DP_SPLIT)
        begin
            pa_reg <= pa_c;
            pb_reg <= pb_c;
            px_reg <= best_rect_reg.x;
            py_reg <= ymin;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            best_reg  <= '0;
            parts_reg <= '0;
            fits_reg  <= 1'b0;
            ovf_reg   <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            best_reg  <= (cmd.op == DP_SCAN_RD && cmd.addr == '0) ? '0 : best_next;
            parts_reg <= parts_next;
            fits_reg  <= fits_next;
            ovf_reg   <= ovf_next;
            hit_reg   <= hit_next;
        end
    end

    assign stat = '{fits: fits_reg, overflow: ovf_reg, parts: parts_reg,
                    merge_hit: hit_reg, count: count_reg, best: best_reg};
    assign place_x = px_reg;
    assign place_y = py_reg;

endmodule

/* design/grp_ctrl.sv */
// ============================================================================
// grp_ctrl: sequencer of the guillotine rectangle packer
// Walks scan, split, removal, append and merge passes, at most one command a cycle.
// ============================================================================
module grp_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_fire,
    input  logic                  op,
    input  logic                  out_taken,
    input  grp_pkg::dp_stat_t     stat,
    output grp_pkg::dp_cmd_t      cmd,
    output logic                  busy,
    output logic                  done,
    output logic [1:0]            status
);
    import grp_pkg::*;

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_START   = 5'd1;
    localparam logic [4:0] S_SRD     = 5'd2;
    localparam logic [4:0] S_SCMP    = 5'd3;
    localparam logic [4:0] S_BRD     = 5'd4;
    localparam logic [4:0] S_BLAT    = 5'd5;
    localparam logic [4:0] S_SPLIT   = 5'd6;
    localparam logic [4:0] S_DECIDE  = 5'd7;
    localparam logic [4:0] S_SHRD    = 5'd8;
    localparam logic [4:0] S_SHWR    = 5'd9;
    localparam logic [4:0] S_DEC     = 5'd10;
    localparam logic [4:0] S_APP     = 5'd11;
    localparam logic [4:0] S_MRDA    = 5'd12;
    localparam logic [4:0] S_MRDB    = 5'd13;
    localparam logic [4:0] S_MWAIT   = 5'd14;
    localparam logic [4:0] S_MCMP    = 5'd15;
    localparam logic [4:0] S_MTEST   = 5'd16;
    localparam logic [4:0] S_MWR     = 5'd17;
    localparam logic [4:0] S_MNEXT   = 5'd18;
    localparam logic [4:0] S_DONE    = 5'd19;
    localparam logic [4:0] S_SCMPW   = 5'd20;

    logic [4:0]       state_reg, state_next;
    logic [CNT_W-1:0] i_reg, i_next, j_reg, j_next;
    logic [1:0]       st_reg, st_next;
    logic             mode_reg, mode_next; // 0 removal of best, 1 merge removal

    always_comb
    begin
        state_next = state_reg;
        i_next = i_reg;
        j_next = j_reg;
        st_next = st_reg;
        mode_next = mode_reg;
        cmd = '{op: DP_NOP, addr: '0};
        unique case (state_reg)
            S_IDLE:
                if (in_fire)
                begin
                    if (op == OP_START)
                        state_next = S_START;
                    else if (stat.count == '0)
                    begin
                        st_next = ST_NOFIT;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        i_next = '0;
                        state_next = S_SRD;
                    end
                end
            S_START:
            begin
                cmd.op = DP_START;
                st_next = ST_START;
                state_next = S_DONE;
            end
            S_SRD:
            begin
                cmd = '{op: DP_SCAN_RD, addr: i_reg};
                state_next = S_SCMPW;
            end
            S_SCMPW:
            begin
                // Read data lands now; entry 0 seeds the best.
                state_next = (i_reg == '0) ? S_SCMP : S_SCMP;
                cmd = '{op: DP_NOP, addr: i_reg};
                if (i_reg == '0)
                begin
                    i_next = CNT_W'(1);
                    state_next = (stat.count == CNT_W'(1)) ? S_SPLIT : S_SRD;
                end
            end
            S_SCMP:
            begin
                cmd = '{op: DP_SCAN_CMP, addr: i_reg};
                i_next = i_reg + 1'b1;
                state_next = (i_reg + 1'b1 == stat.count) ? S_SPLIT : S_SRD;
            end
            S_SPLIT:
            begin
                cmd.op = DP_SPLIT;
                state_next = S_DECIDE;
            end
            S_DECIDE:
                if (!stat.fits)
                begin
                    st_next = ST_NOFIT;
                    state_next = S_DONE;
                end
                else if (stat.overflow)
                begin
                    st_next = ST_NOSLOT;
                    state_next = S_DONE;
                end
                else
                begin
                    st_next = ST_PLACED;
                    mode_next = 1'b0;
                    i_next = {1'b0, stat.best};
                    state_next = S_SHRD;
                end
            S_SHRD:
                if (i_reg + 1'b1 >= stat.count)
                    state_next = S_DEC;
                else
                begin
                    cmd = '{op: DP_SHIFT_RD, addr: i_reg + 1'b1};
                    state_next = S_SHWR;
                end
            S_SHWR:
            begin
                cmd = '{op: DP_SHIFT_WR, addr: i_reg};
                i_next = i_reg + 1'b1;
                state_next = S_SHRD;
            end
            S_DEC:
            begin
                cmd = '{op: DP_NOP, addr: '1};
                i_next = '0;
                j_next = '0;
                state_next = mode_reg ? S_MRDA : S_APP;
            end
            S_APP:
                if (stat.parts == 2'd0)
                    state_next = S_MRDA;
                else
                    cmd.op = DP_APPEND;
            S_MRDA:
                if (i_reg >= stat.count)
                    state_next = S_DONE;
                else if (j_reg >= stat.count)
                begin
                    i_next = i_reg + 1'b1;
                    j_next = '0;
                end
                else if (i_reg == j_reg)
                    j_next = j_reg + 1'b1;
                else
                begin
                    cmd = '{op: DP_MRG_RDA, addr: i_reg};
                    state_next = S_MRDB;
                end
            S_MRDB:
            begin
                cmd = '{op: DP_MRG_RDB, addr: j_reg};
                state_next = S_MWAIT;
            end
            S_MWAIT:
            begin
                cmd = '{op: DP_MRG_CMP, addr: j_reg};
                state_next = S_MTEST;
            end
            S_MTEST:
                if (stat.merge_hit)
                    state_next = S_MWR;
                else
                begin
                    j_next = j_reg + 1'b1;
                    state_next = S_MRDA;
                end
            S_MWR:
            begin
                cmd = '{op: DP_MRG_WR, addr: j_reg};
                mode_next = 1'b1;
                state_next = S_SHRD;
            end
            S_DONE:
            begin
                state_next = S_MNEXT;
            end
            S_MNEXT:
                if (out_taken)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            i_reg <= '0;
            j_reg <= '0;
            st_reg <= ST_NOFIT;
            mode_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg <= i_next;
            j_reg <= j_next;
            st_reg <= st_next;
            mode_reg <= mode_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_MNEXT);
    assign status = st_reg;

endmodule

/* design/guillotine_rect_packer_top.sv */
// ============================================================================
// guillotine_rect_packer_top: best short side fit guillotine packer
// Keeps an ordered free-rectangle list and places sprites one at a time.
// ============================================================================
//
//  Channel   Signals                          Width
//  in        in_valid/in_ready/in_data        29-bit in_item_t
//  out       out_valid/out_ready/out_data     30-bit out_item_t
//  cfg       cfg_we/cfg_index/cfg_data        1 + 14 bits
//
// One transaction is handled at a time. A place scans the N free rectangles,
// splits the best one, removes it from the list, appends the parts and then
// runs the merge pass; the merge pass starts over after every merge.
// Reset clears the free count, so the list is empty; the RAM needs no sweep.
// A stalled result waits in the status and place registers while the block holds.
//
module guillotine_rect_packer_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  grp_pkg::in_item_t            in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output grp_pkg::out_item_t           out_data,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [grp_pkg::SIDE_W-1:0]   cfg_data
);
    import grp_pkg::*;

    logic [SIDE_W-1:0] aw_reg, ah_reg, cfg_sat;
    in_item_t          item_reg;
    dp_cmd_t           cmd;
    dp_stat_t          stat;
    logic              busy, done;
    logic [1:0]        status;
    logic [SIDE_W-1:0] px, py;
    logic              in_fire;

    // Writes above the maximum side saturate.
    assign cfg_sat = (cfg_data > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : cfg_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aw_reg <= SIDE_W'(1024);
            ah_reg <= SIDE_W'(1024);
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_ATLAS_WIDTH)
                aw_reg <= cfg_sat;
            else
                ah_reg <= cfg_sat;
        end
    end

    assign in_ready = !busy;
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk)
    begin
        if (in_fire)
            item_reg <= in_data;
    end

    grp_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .op(in_data.op),
        .out_taken(out_ready), .stat(stat), .cmd(cmd), .busy(busy),
        .done(done), .status(status)
    );

    grp_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .item(item_reg),
        .atlas_width(aw_reg), .atlas_height(ah_reg), .stat(stat),
        .place_x(px), .place_y(py)
    );

    assign out_valid = done;
    always_comb
    begin
        out_data = '{status: status, x_min: '0, y_min: '0};
        if (status == ST_PLACED)
        begin
            out_data.x_min = px;
            out_data.y_min = py;
        end
    end

endmodule

/* design/grp_checker.sv */
// ============================================================================
// grp_checker: port-level checks of the guillotine rectangle packer
// Watches the handshakes and the result codes.
// ============================================================================
module grp_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               out_valid,
    input  logic               out_ready,
    input  grp_pkg::out_item_t out_data
);
    import grp_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while result pending");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_PLACED |->
        out_data.x_min == '0 && out_data.y_min == '0)
        else $error("coordinates not zero");

    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second transaction accepted");

endmodule

bind guillotine_rect_packer_top grp_checker u_grp_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

/* sim/tb.sv */
// ============================================================================
// tb: self-checking testbench of the guillotine rectangle packer
// Drives start and place transactions through the valid/ready input channel,
// predicts each result with a behavioral packer kept in the testbench, and
// compares every output transaction against the oldest prediction.
// ============================================================================
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import grp_pkg::*;

    localparam int  MASK_14     = 16'h3FFF;
    localparam longint CYCLE_LIMIT = 100_000_000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;
    logic      cfg_we;
    logic      cfg_index;
    logic [SIDE_W-1:0] cfg_data;

    guillotine_rect_packer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Behavioral copy of the packer state: the ordered free list and the
    // configured atlas size.
    int free_x [FREE_SLOTS];
    int free_y [FREE_SLOTS];
    int free_w [FREE_SLOTS];
    int free_h [FREE_SLOTS];
    int free_count;
    int atlas_w;
    int atlas_h;

    out_item_t pending_results[$];
    int        mismatch_count;
    longint    cycle_count;
    // When set, both sides run without idle cycles.
    bit        no_idle;

    // ------------------------------------------------------------------------
    // Clock, reset and the run watchdog.
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Packer model.
    // ------------------------------------------------------------------------

    // Shorter of the two leftovers when the sprite goes into entry k; it is
    // negative when the sprite does not fit along that side.
    function automatic int short_leftover(int k, int sw, int sh);
        int dw;
        int dh;
        dw = free_w[k] - sw;
        dh = free_h[k] - sh;
        return (dw < dh) ? dw : dh;
    endfunction

    // Best short side fit: entry c beats entry b. When either leftover is
    // negative the larger leftover wins, so a fitting entry beats one that
    // does not fit.
    function automatic bit beats_best(int c, int b, int sw, int sh);
        int lc;
        int lb;
        int lo;
        lc = short_leftover(c, sw, sh);
        lb = short_leftover(b, sw, sh);
        lo = (lc < lb) ? lc : lb;
        if (lo < 0)
            return lb < lc;
        return lc < lb;
    endfunction

    function automatic void drop_entry(int k);
        for (int m = k; m + 1 < free_count; m++)
        begin
            free_x[m] = free_x[m + 1];
            free_y[m] = free_y[m + 1];
            free_w[m] = free_w[m + 1];
            free_h[m] = free_h[m + 1];
        end
        free_count--;
    endfunction

    function automatic void add_entry(int x, int y, int w, int h);
        free_x[free_count] = x;
        free_y[free_count] = y;
        free_w[free_count] = w;
        free_h[free_count] = h;
        free_count++;
    endfunction

    // Merge entry i into entry j when i sits directly above j or directly to
    // its right with the same span. After every merge the scan starts over
    // from the first pair (i = 0, next j = 1).
    function automatic void merge_neighbors();
        int i;
        int j;
        i = 0;
        while (i < free_count)
        begin
            j = 0;
            while (j < free_count)
            begin
                if (i != j)
                begin
                    if (free_x[i] == free_x[j] && free_w[i] == free_w[j] &&
                        free_y[i] == free_y[j] + free_h[j])
                    begin
                        free_h[j] = (free_h[j] + free_h[i]) & MASK_14;
                        drop_entry(i);
                        i = 0;
                        j = 0;
                    end
                    else if (free_y[i] == free_y[j] && free_h[i] == free_h[j] &&
                             free_x[i] == free_x[j] + free_w[j])
                    begin
                        free_w[j] = (free_w[j] + free_w[i]) & MASK_14;
                        drop_entry(i);
                        i = 0;
                        j = 0;
                    end
                end
                j++;
            end
            i++;
        end
    endfunction

    function automatic out_item_t pack_result(in_item_t item);
        out_item_t res;
        int sw;
        int sh;
        int best;
        int rx, ry, rw, rh;
        int ax, ay, aw, ah;
        int bx, by, bw, bh;
        int ymin;
        int added;
        res.status = ST_NOFIT;
        res.x_min  = '0;
        res.y_min  = '0;
        sw = int'(item.sprite_width);
        sh = int'(item.sprite_height);
        if (item.op == OP_START)
        begin
            free_count = 0;
            add_entry(0, 0, atlas_w, atlas_h);
            res.status = ST_START;
            return res;
        end
        if (free_count == 0)
            return res;
        best = 0;
        for (int k = 1; k < free_count; k++)
            if (beats_best(k, best, sw, sh))
                best = k;
        rx = free_x[best];
        ry = free_y[best];
        rw = free_w[best];
        rh = free_h[best];
        if (rw < sw || rh < sh)
            return res;
        ymin = ry + rh - sh;
        // Split along the shorter axis of the chosen rectangle.
        if (rw < rh)
        begin
            ax = rx + sw; ay = ry;   aw = rw - sw; ah = rh;
            bx = rx;      by = ry;   bw = sw;      bh = rh - sh;
        end
        else
        begin
            ax = rx;      ay = ry;   aw = rw;      ah = rh - sh;
            bx = rx + sw; by = ymin; bw = rw - sw; bh = sh;
        end
        added = 0;
        if (aw != 0 && ah != 0)
            added++;
        if (bw != 0 && bh != 0)
            added++;
        if (free_count - 1 + added > FREE_SLOTS)
        begin
            res.status = ST_NOSLOT;
            return res;
        end
        drop_entry(best);
        if (aw != 0 && ah != 0)
            add_entry(ax, ay, aw, ah);
        if (bw != 0 && bh != 0)
            add_entry(bx, by, bw, bh);
        merge_neighbors();
        res.status = ST_PLACED;
        res.x_min  = SIDE_W'(rx & MASK_14);
        res.y_min  = SIDE_W'(ymin & MASK_14);
        return res;
    endfunction

    // Mostly zero, sometimes a short gap, rarely a long pause.
    function automatic int random_gap();
        int pick;
        pick = $urandom_range(99);
        if (pick < 65)
            return 0;
        if (pick < 95)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // ------------------------------------------------------------------------
    // Result checker: outputs are sampled at the rising edge.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transaction: status %0d", out_data.status);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_data.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, out_data.status);
                    mismatch_count++;
                end
                if (out_data.x_min !== want.x_min)
                begin
                    $error("x_min: expected %0d, got %0d", want.x_min, out_data.x_min);
                    mismatch_count++;
                end
                if (out_data.y_min !== want.y_min)
                begin
                    $error("y_min: expected %0d, got %0d", want.y_min, out_data.y_min);
                    mismatch_count++;
                end
            end
        end
    end

    // The receiver stalls at random, mostly briefly, except in idle-free runs.
    initial
    begin
        int stall;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (no_idle)
                out_ready = 1'b1;
            else
            begin
                stall = random_gap();
                if (stall == 0)
                    out_ready = 1'b1;
                else
                begin
                    out_ready = 1'b0;
                    repeat (stall - 1) @(negedge clk);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------

    // Offers one transaction and holds it until the block takes it. Valid
    // stays high into the next call when no gap follows.
    task automatic send_item(logic op, int sw, int sh);
        int gap;
        @(negedge clk);
        in_data.op            = op;
        in_data.sprite_width  = sw[SIDE_W-1:0];
        in_data.sprite_height = sh[SIDE_W-1:0];
        in_valid              = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.insert(pending_results.size(), pack_result(in_data));
        gap = no_idle ? 0 : random_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // Registers change only while the block is idle.
    task automatic write_atlas(int w, int h);
        wait_drained();
        cfg_we    = 1'b1;
        cfg_index = CFG_ATLAS_WIDTH;
        cfg_data  = w[SIDE_W-1:0];
        @(negedge clk);
        cfg_index = CFG_ATLAS_HEIGHT;
        cfg_data  = h[SIDE_W-1:0];
        @(negedge clk);
        cfg_we    = 1'b0;
        atlas_w   = ((w & MASK_14) > MAX_SIDE) ? MAX_SIDE : (w & MASK_14);
        atlas_h   = ((h & MASK_14) > MAX_SIDE) ? MAX_SIDE : (h & MASK_14);
    endtask

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Reset size, place before any start, exact fit, and a full atlas.
    task automatic test_reset_and_basics();
        send_item(OP_PLACE, 1, 1);
        send_item(OP_START, 16383, 16383);
        send_item(OP_PLACE, 1025, 1);
        send_item(OP_PLACE, 1024, 1024);
        send_item(OP_PLACE, 1, 1);
        send_item(OP_START, 0, 0);
        send_item(OP_PLACE, 512, 256);
        send_item(OP_PLACE, 256, 512);
        send_item(OP_PLACE, 512, 768);
        send_item(OP_PLACE, 256, 512);
    endtask

    // Extreme atlas and sprite sizes, zero sizes and register saturation.
    task automatic test_extremes();
        write_atlas(16383, 8193);
        send_item(OP_START, 0, 0);
        send_item(OP_PLACE, 8192, 1);
        send_item(OP_PLACE, 0, 5);
        send_item(OP_PLACE, 7, 0);
        send_item(OP_PLACE, 16383, 16383);
        send_item(OP_PLACE, 1, 8191);
        write_atlas(1, 1);
        send_item(OP_START, 0, 0);
        send_item(OP_PLACE, 1, 1);
        send_item(OP_PLACE, 1, 1);
        write_atlas(0, 8192);
        send_item(OP_START, 10922, 5461);
        send_item(OP_PLACE, 0, 0);
        send_item(OP_PLACE, 1, 1);
    endtask

    // Many small, random sprites in a big atlas fill the free list and can push
    // the table to overflow.
    task automatic test_slot_exhaustion();
        no_idle = 1'b1;
        write_atlas(8192, 8192);
        send_item(OP_START, 0, 0);
        for (int k = 0; k < 72; k++)
            send_item(OP_PLACE, $urandom_range(60, 1), $urandom_range(60, 1));
        no_idle = 1'b0;
    endtask

    // Random phases: each picks an atlas size, starts a pack and places mostly
    // fitting sprites, with occasional restarts and out-of-range sizes.
    task automatic test_random_packing();
        int aw;
        int ah;
        int pick;
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: begin aw = 64;   ah = 64;   end
                1: begin aw = 8192; ah = 16;   end
                2: begin aw = $urandom_range(300, 20); ah = $urandom_range(300, 20); end
                default: begin aw = $urandom_range(2000, 1); ah = $urandom_range(2000, 1); end
            endcase
            write_atlas(aw, ah);
            no_idle = (phase == 2);
            send_item(OP_START, $urandom_range(16383), $urandom_range(16383));
            for (int k = 0; k < 8; k++)
            begin
                // The sender waits for every result once, mid-phase.
                if (phase == 3 && k == 4)
                    wait_drained();
                pick = $urandom_range(99);
                if (pick < 7)
                    send_item(OP_START, $urandom_range(16383), $urandom_range(16383));
                else if (pick < 15)
                    send_item(OP_PLACE, $urandom_range(16383), $urandom_range(16383));
                else
                    send_item(OP_PLACE, $urandom_range(atlas_w / 3 + 1, 0),
                              $urandom_range(atlas_h / 3 + 1, 0));
            end
        end
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_ATLAS_WIDTH;
        cfg_data       = '0;
        no_idle        = 1'b0;
        mismatch_count = 0;
        free_count     = 0;
        atlas_w        = 1024;
        atlas_h        = 1024;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_and_basics();
        test_extremes();
        test_slot_exhaustion();
        test_random_packing();

        wait_drained();
        repeat (50) @(negedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
